/* rtl/tsdcq_pkg.sv */
// ----------------------------------------------------------------------------
// tsdcq_pkg
// shared types and constants of the tau spectrum density / cdf / quantile block
// ----------------------------------------------------------------------------
package tsdcq_pkg;

  localparam int FRAC_BITS    = 30;
  localparam int BISECT_STEPS = 30;
  localparam int WORD_W       = 32;
  localparam int VAL_W        = 40;
  localparam int MUL_A_W      = 32;
  localparam int MUL_B_W      = 34;
  localparam int FULL_W       = MUL_A_W + MUL_B_W;
  localparam int PROD_W       = FULL_W - FRAC_BITS;
  localparam int DIV_SHIFT    = 3;
  localparam int STEP_W       = 4;
  localparam int ITER_W       = $clog2(BISECT_STEPS);

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [FRAC_BITS:0]       unit_t;

  localparam longint ONE_L = longint'(1) << FRAC_BITS;

  localparam val_t  ONE_Q   = val_t'(ONE_L);
  localparam val_t  TWO_Q   = val_t'(2 * ONE_L);
  localparam val_t  FIVE_Q  = val_t'(5 * ONE_L);
  localparam val_t  C13_Q   = val_t'(ONE_L / 3);
  localparam val_t  C43_Q   = val_t'((4 * ONE_L) / 3);
  localparam val_t  C53_Q   = val_t'((5 * ONE_L) / 3);
  localparam val_t  C83_Q   = val_t'((8 * ONE_L) / 3);
  // ceil(2^(frac+3) / 3), rounded-up reciprocal for the divide by three
  localparam val_t  RECIP3_Q = val_t'(((ONE_L << DIV_SHIFT) + 2) / 3);
  localparam val_t  HALF_Q  = val_t'(ONE_L / 2);
  localparam unit_t ONE_U   = unit_t'(ONE_L);
  localparam word_t POL_MAX = word_t'(ONE_L);
  localparam word_t POL_MIN = word_t'(-ONE_L);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(BISECT_STEPS - 1);

  typedef enum logic [1:0] {
    CMD_DENSITY  = 2'd0,
    CMD_CDF      = 2'd1,
    CMD_EXCEED   = 2'd2,
    CMD_QUANTILE = 2'd3
  } cmd_t;

  typedef struct packed {
    val_t a;
    val_t b;
  } mul_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] mag;
    logic              neg;
  } mul_res_t;

  typedef struct packed {
    logic valid;
    val_t value;
    logic bad;
  } fin_t;

endpackage

/* rtl/tsdcq_mul.sv */
// ----------------------------------------------------------------------------
// tsdcq_mul
// shared signed fixed-point multiplier, product truncated toward zero, registered
// ----------------------------------------------------------------------------
module tsdcq_mul (
  input  logic                clk,
  input  tsdcq_pkg::mul_req_t req,
  output tsdcq_pkg::mul_res_t res
);
  import tsdcq_pkg::*;

  logic [VAL_W-1:0]  abs_a;
  logic [VAL_W-1:0]  abs_b;
  logic [FULL_W-1:0] full;
  mul_res_t          res_r;
  mul_res_t          res_nxt;

  always_comb begin
    abs_a       = req.a[VAL_W-1] ? VAL_W'(-req.a) : VAL_W'(req.a);
    abs_b       = req.b[VAL_W-1] ? VAL_W'(-req.b) : VAL_W'(req.b);
    full        = FULL_W'(abs_a[MUL_A_W-1:0]) * FULL_W'(abs_b[MUL_B_W-1:0]);
    res_nxt.mag = full[FULL_W-1:FRAC_BITS];
    res_nxt.neg = req.a[VAL_W-1] ^ req.b[VAL_W-1];
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

/* rtl/tsdcq_core.sv */
// ----------------------------------------------------------------------------
// tsdcq_core
// sequencer for density, cdf, exceedance and bisection quantile over the shared multiplier
// ----------------------------------------------------------------------------
module tsdcq_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [1:0]        cmd,
  input  logic signed [31:0] argument,
  input  tsdcq_pkg::word_t  polarization,
  output logic              busy,
  output tsdcq_pkg::fin_t   fin
);
  import tsdcq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  word_t             arg_r, arg_nxt;
  val_t              x_r, x_nxt;
  val_t              x2_r, x2_nxt;
  val_t              x3_r, x3_nxt;
  val_t              acc_r, acc_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  unit_t             lo_r, lo_nxt;
  unit_t             hi_r, hi_nxt;

  mul_req_t          req;
  mul_res_t          res;
  val_t              pv;
  val_t              dv;
  val_t              pol;
  val_t              ax;
  val_t              rv;
  cmd_t              in_cmd;
  unit_t             lo_n;
  unit_t             hi_n;
  logic [FRAC_BITS+1:0] sum_n;

  tsdcq_mul u_mul (
    .clk (clk),
    .req (req),
    .res (res)
  );

  always_comb begin
    pv     = res.neg ? -val_t'(res.mag) : val_t'(res.mag);
    dv     = res.neg ? -val_t'(res.mag >> DIV_SHIFT) : val_t'(res.mag >> DIV_SHIFT);
    pol    = val_t'(polarization);
    ax     = val_t'(argument);
    rv     = val_t'(arg_r);
    in_cmd = cmd_t'(cmd);
    lo_n   = lo_r;
    hi_n   = hi_r;
    if (dv > rv) begin
      hi_n = x_r[FRAC_BITS:0];
    end else begin
      lo_n = x_r[FRAC_BITS:0];
    end
    sum_n  = {1'b0, lo_n} + {1'b0, hi_n};
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    arg_nxt   = arg_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    x3_nxt    = x3_r;
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    iter_nxt  = iter_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    req.a     = '0;
    req.b     = '0;
    fin       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          cmd_nxt  = in_cmd;
          arg_nxt  = argument;
          x_nxt    = ax;
          step_nxt = '0;
          unique case (in_cmd)
            CMD_DENSITY: begin
              if (ax < 0 || ax >= ONE_Q) begin
                fin.valid = 1'b1;
              end else begin
                state_nxt = ST_EVAL;
              end
            end
            CMD_CDF, CMD_EXCEED: begin
              if (ax <= 0) begin
                fin.valid = 1'b1;
                fin.value = (in_cmd == CMD_EXCEED) ? ONE_Q : '0;
              end else if (ax >= ONE_Q) begin
                fin.valid = 1'b1;
                fin.value = (in_cmd == CMD_EXCEED) ? '0 : ONE_Q;
              end else begin
                state_nxt = ST_EVAL;
              end
            end
            CMD_QUANTILE: begin
              fin.bad = (ax < 0) || (ax > ONE_Q);
              if (ax <= 0) begin
                fin.valid = 1'b1;
              end else if (ax >= ONE_Q) begin
                fin.valid = 1'b1;
                fin.value = ONE_Q;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = ONE_U;
                iter_nxt  = '0;
                x_nxt     = HALF_Q;
                state_nxt = ST_EVAL;
              end
            end
            default: begin
              fin.valid = 1'b1;
            end
          endcase
        end
      end

      ST_EVAL: begin
        step_nxt = step_r + STEP_W'(1);
        if (cmd_r == CMD_DENSITY) begin
          unique case (step_r)
            4'd0: begin
              req.a = x_r;
              req.b = x_r;
            end
            4'd1: begin
              x2_nxt = pv;
              req.a  = x_r;
              req.b  = pv;
            end
            4'd2: begin
              x3_nxt = pv;
              req.a  = C43_Q;
              req.b  = pv;
            end
            4'd3: begin
              acc_nxt = C53_Q - ((x2_r <<< 1) + x2_r) + pv;
              req.a   = C83_Q;
              req.b   = x3_r;
            end
            4'd4: begin
              x3_nxt = C13_Q - ((x2_r <<< 1) + x2_r) + pv;
            end
            4'd5: begin
              req.a = pol;
              req.b = x3_r;
            end
            4'd6: begin
              fin.valid = 1'b1;
              fin.value = acc_r - pv;
              state_nxt = ST_IDLE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end else begin
          unique case (step_r)
            4'd0: begin
              req.a = x_r;
              req.b = x_r;
            end
            4'd1: begin
              x2_nxt = pv;
              req.a  = x_r;
              req.b  = pv;
            end
            4'd2: begin
              x3_nxt = pv;
              req.a  = x_r - ONE_Q;
              req.b  = x_r - ONE_Q;
            end
            4'd3: begin
              req.a = (x_r <<< 1) + ONE_Q;
              req.b = pv;
            end
            4'd4: begin
              req.a = pol;
              req.b = pv;
            end
            4'd5: begin
              acc_nxt = FIVE_Q - ((x2_r <<< 1) + x2_r) + x3_r - pv;
            end
            4'd6: begin
              req.a = x_r;
              req.b = acc_r;
            end
            4'd7: begin
              req.a = RECIP3_Q;
              req.b = pv;
            end
            4'd8: begin
              unique case (cmd_r)
                CMD_CDF: begin
                  fin.valid = 1'b1;
                  fin.value = dv;
                  state_nxt = ST_IDLE;
                end
                CMD_EXCEED: begin
                  fin.valid = 1'b1;
                  fin.value = ONE_Q - dv;
                  state_nxt = ST_IDLE;
                end
                default: begin
                  if (dv == rv) begin
                    fin.valid = 1'b1;
                    fin.value = x_r;
                    state_nxt = ST_IDLE;
                  end else if (iter_r == ITER_LAST) begin
                    fin.valid = 1'b1;
                    fin.value = val_t'(sum_n[FRAC_BITS+1:1]);
                    state_nxt = ST_IDLE;
                  end else begin
                    lo_nxt   = lo_n;
                    hi_nxt   = hi_n;
                    x_nxt    = val_t'(sum_n[FRAC_BITS+1:1]);
                    iter_nxt = iter_r + ITER_W'(1);
                    step_nxt = '0;
                  end
                end
              endcase
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    arg_r <= arg_nxt;
    x_r   <= x_nxt;
    x2_r  <= x2_nxt;
    x3_r  <= x3_nxt;
    acc_r <= acc_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* rtl/tau_spectrum_density_cdf_quantile_top.sv */
// ----------------------------------------------------------------------------
// tau_spectrum_density_cdf_quantile_top
// polarization-dependent tau energy-fraction spectrum: density, cdf,
// exceedance and quantile by bisection, one shared multiplier
// ----------------------------------------------------------------------------
// latency runs from the accept edge to the strobe: density passes once through its
// multiply steps, cdf and exceedance once through theirs, quantile once per bisection step
// arguments outside [0,1], and on its edges but for a density at 0, answer from idle
// busy holds off the next request until the strobe cycle, one sequencer step per cycle
// rst_n synchronous active low: polarization cleared to 0, sequencer idle
// result shown for one cycle on out_strobe, the receiver cannot stall
module tau_spectrum_density_cdf_quantile_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_argument,
  output logic               out_strobe,
  output logic [31:0]        out_value,
  output logic               out_bad_argument,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data
);
  import tsdcq_pkg::*;

  word_t        pol_r, pol_nxt;
  word_t        cfg_s;
  fin_t         fin;
  logic         core_busy;
  logic         strobe_r;
  logic [31:0]  value_r, value_nxt;
  logic         bad_r;

  tsdcq_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (start),
    .cmd          (in_cmd),
    .argument     (in_argument),
    .polarization (pol_r),
    .busy         (core_busy),
    .fin          (fin)
  );

  // polarization saturates to +-1 on write
  always_comb begin
    cfg_s   = word_t'(cfg_data);
    pol_nxt = pol_r;
    if (cfg_we) begin
      priority if (cfg_s > POL_MAX) begin
        pol_nxt = POL_MAX;
      end else if (cfg_s < POL_MIN) begin
        pol_nxt = POL_MIN;
      end else begin
        pol_nxt = cfg_s;
      end
    end
  end

  // output saturates to 0..2
  always_comb begin
    priority if (fin.value < 0) begin
      value_nxt = '0;
    end else if (fin.value > TWO_Q) begin
      value_nxt = TWO_Q[31:0];
    end else begin
      value_nxt = fin.value[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      pol_r    <= pol_nxt;
      strobe_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) begin
      value_r <= value_nxt;
      bad_r   <= fin.bad;
    end
  end

  assign busy             = core_busy;
  assign out_strobe       = strobe_r;
  assign out_value        = value_r;
  assign out_bad_argument = bad_r;

endmodule
